[sv/adb_tablet_device_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the tablet core RTL
// Clocked, reset-gated wrappers for concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ADB_TABLET_DEVICE_CORE_MACROS_SVH
`define ADB_TABLET_DEVICE_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ADBT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ADBT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

[sv/adbt_pkg.sv]
// ----------------------------------------------------------------------------
// adbt_pkg
// Types, command codes and scaling constants for the ADB tablet core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adbt_pkg;

	// Host event kinds
	localparam logic [1:0] ACT_MOVE   = 2'd0;
	localparam logic [1:0] ACT_BUTTON = 2'd1;
	localparam logic [1:0] ACT_CMD    = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	localparam logic [1:0] BTN_LEFT  = 2'd0;
	localparam logic [1:0] BTN_RIGHT = 2'd1;

	// ADB command byte: low nibble is kind (bits 3..2) and register (bits 1..0)
	localparam logic [3:0] CMD_FLUSH   = 4'h1;
	localparam logic [1:0] KIND_LISTEN = 2'b10;
	localparam logic [1:0] KIND_TALK   = 2'b11;
	localparam logic [1:0] REG_0       = 2'd0;
	localparam logic [1:0] REG_1       = 2'd1;
	localparam logic [1:0] REG_3       = 2'd3;

	localparam logic [3:0] LISTEN_LEN    = 4'd3;
	localparam logic [7:0] ARG_SELF_TEST = 8'hFF;
	localparam logic [7:0] HANDLER_ID    = 8'h3A;
	localparam logic [3:0] ADDR_DEFAULT  = 4'd4;
	localparam logic [7:0] PKT_SYNC      = 8'hC0;

	// Identity string, first byte in the lowest lane
	localparam logic [7:0][7:0] ID_BYTES = {
		8'h04, 8'h38, 8'h30, 8'h36, 8'h30, 8'h43, 8'h41, 8'h57
	};
	localparam logic [3:0] ID_LEN  = 4'd8;
	localparam logic [3:0] PKT_LEN = 4'd5;
	localparam logic [3:0] REG3_LEN = 4'd2;

	// Configuration registers
	localparam int CFG_DATA_W = 13;
	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;
	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;

	// Scaling: q = floor(P / D) with P < 2^28, by reciprocal plus one fixup
	localparam int PROD_W = 28;
	localparam int EST_W  = 46;
	localparam int QE_W   = 18;
	localparam logic [PROD_W-1:0] DIV_X = 28'd2450;
	localparam logic [PROD_W-1:0] DIV_Y = 28'd1905;
	localparam logic [17:0] RECIP_X = 18'((64'd1 << PROD_W) / 64'd2450);
	localparam logic [17:0] RECIP_Y = 18'((64'd1 << PROD_W) / 64'd1905);

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  axis;
		logic [14:0] position;
		logic [1:0]  button_id;
		logic        pressed;
		logic [7:0]  cmd_byte;
		logic [7:0]  arg_one;
		logic [7:0]  arg_two;
		logic [3:0]  message_length;
	} item_t;

	// One response burst handed from the front to the back
	typedef struct packed {
		logic [7:0][7:0] bytes;
		logic [3:0]      count;
		logic            has_data;
	} job_t;

endpackage

`default_nettype wire

[sv/adbt_if.sv]
// ----------------------------------------------------------------------------
// adbt_if
// Valid/ready channels for host items and ADB result bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface adbt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [1:0]  axis;
	logic [14:0] position;
	logic [1:0]  button_id;
	logic        pressed;
	logic [7:0]  cmd_byte;
	logic [7:0]  arg_one;
	logic [7:0]  arg_two;
	logic [3:0]  message_length;

	modport source (
		output valid, action, axis, position, button_id, pressed,
		output cmd_byte, arg_one, arg_two, message_length,
		input ready
	);
	modport sink (
		input valid, action, axis, position, button_id, pressed,
		input cmd_byte, arg_one, arg_two, message_length,
		output ready
	);
endinterface

interface adbt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;
	logic       has_data;

	modport source (output valid, data_byte, byte_valid, last, has_data, input ready);
	modport sink (input valid, data_byte, byte_valid, last, has_data, output ready);
endinterface

`default_nettype wire

[sv/adbt_fifo.sv]
// ----------------------------------------------------------------------------
// adbt_fifo
// Short job queue between the front classifier and the byte serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "adb_tablet_device_core_macros.svh"

module adbt_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  adbt_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output adbt_pkg::job_t pop_data,
	output logic           empty
);
	import adbt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	`ADBT_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full && !pop, "job pushed into full queue")
	`ADBT_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty, "job popped from empty queue")

endmodule

`default_nettype wire

[sv/adbt_front.sv]
// ----------------------------------------------------------------------------
// adbt_front
// Three-stage front: scales moves, applies state, builds response jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "adb_tablet_device_core_macros.svh"

module adbt_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [0:0]                      cfg_index,
	input  logic [adbt_pkg::CFG_DATA_W-1:0] cfg_data,
	adbt_in_if.sink                         item,
	output adbt_pkg::job_t                  job,
	output logic                            job_push,
	input  logic                            job_full
);
	import adbt_pkg::*;

	// Configuration and device state
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [1:0]  btn_now_q;
	logic [1:0]  btn_rep_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [3:0]  addr_q;
	logic [7:0]  handler_q;

	// Pipeline
	logic              valid_s1, valid_s2, valid_s3;
	item_t             item_s1, item_s2, item_s3;
	logic [PROD_W-1:0] prod_s1, prod_s2, prod_s3;
	logic [QE_W-1:0]   qe_s2, qe_s3;

	logic ready_s1, ready_s2, ready_s3;
	item_t in_item;

	assign job_push = valid_s3 && !job_full;
	assign ready_s3 = !valid_s3 || !job_full;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign item.ready = ready_s1;

	assign in_item = '{
		action: item.action, axis: item.axis, position: item.position,
		button_id: item.button_id, pressed: item.pressed, cmd_byte: item.cmd_byte,
		arg_one: item.arg_one, arg_two: item.arg_two,
		message_length: item.message_length
	};

	// Stage 1 multiply: position times display size
	logic [CFG_DATA_W-1:0] scale_size;
	logic [PROD_W-1:0]     prod_d;
	assign scale_size = (item.axis == AXIS_Y) ? height_q : width_q;
	assign prod_d     = PROD_W'(item.position) * PROD_W'(scale_size);

	// Stage 2: reciprocal estimate of the quotient
	logic [17:0]       recip_s1;
	logic [EST_W-1:0]  est_d;
	assign recip_s1 = (item_s1.axis == AXIS_Y) ? RECIP_Y : RECIP_X;
	assign est_d    = EST_W'(prod_s1) * EST_W'(recip_s1);

	// Stage 3: fix up the estimate by one
	logic [PROD_W-1:0] div_s3;
	logic [PROD_W-1:0] rem_s3;
	logic [QE_W-1:0]   quot_s3;
	assign div_s3  = (item_s3.axis == AXIS_Y) ? DIV_Y : DIV_X;
	assign rem_s3  = prod_s3 - PROD_W'(PROD_W'(qe_s3) * div_s3);
	assign quot_s3 = qe_s3 + QE_W'(rem_s3 >= div_s3);

	// Hold stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= item.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Advance stage payloads
	always_ff @(posedge clk) begin
		if (ready_s1 && item.valid) begin
			item_s1 <= in_item;
			prod_s1 <= prod_d;
		end
		if (ready_s2 && valid_s1) begin
			item_s2 <= item_s1;
			prod_s2 <= prod_s1;
			qe_s2   <= est_d[PROD_W +: QE_W];
		end
		if (ready_s3 && valid_s2) begin
			item_s3 <= item_s2;
			prod_s3 <= prod_s2;
			qe_s3   <= qe_s2;
		end
	end

	// Classify the item at stage 3 and work out next state and response
	logic [1:0]  btn_now_d, btn_rep_d;
	logic [15:0] x_d, y_d;
	logic        x_nz_d, y_nz_d;
	logic [3:0]  addr_d;
	logic [7:0]  handler_d;
	logic        pend_q;
	job_t        job_d;

	assign pend_q = (btn_now_q != btn_rep_q) || (|x_q) || (|y_q);

	always_comb begin
		btn_now_d = btn_now_q;
		btn_rep_d = btn_rep_q;
		x_d       = x_q;
		y_d       = y_q;
		x_nz_d    = |x_q;
		y_nz_d    = |y_q;
		addr_d    = addr_q;
		handler_d = handler_q;
		job_d     = '0;
		case (item_s3.action)
			ACT_MOVE: begin
				if (item_s3.axis == AXIS_X) begin
					x_d    = quot_s3[15:0];
					x_nz_d = |quot_s3[15:0];
				end else if (item_s3.axis == AXIS_Y) begin
					y_d    = quot_s3[15:0];
					y_nz_d = |quot_s3[15:0];
				end
			end
			ACT_BUTTON: begin
				if (item_s3.button_id == BTN_LEFT || item_s3.button_id == BTN_RIGHT) begin
					btn_now_d[item_s3.button_id[0]] = item_s3.pressed;
				end
			end
			ACT_CMD: begin
				if (item_s3.cmd_byte[3:0] == CMD_FLUSH) begin
					// Drop unreported motion and restore the last sent buttons
					btn_now_d = btn_rep_q;
					x_d = '0;
					y_d = '0;
					x_nz_d = 1'b0;
					y_nz_d = 1'b0;
				end else begin
					case (item_s3.cmd_byte[3:2])
						KIND_LISTEN: begin
							// Self-test leaves all alone; handler only moves to our own id
							if (item_s3.cmd_byte[1:0] == REG_3 &&
								item_s3.message_length == LISTEN_LEN &&
								item_s3.arg_two != ARG_SELF_TEST) begin
								addr_d = item_s3.arg_one[3:0];
								if (item_s3.arg_two == HANDLER_ID) begin
									handler_d = HANDLER_ID;
								end
							end
						end
						KIND_TALK: begin
							case (item_s3.cmd_byte[1:0])
								REG_0: begin
									if (pend_q) begin
										job_d.bytes[0] = PKT_SYNC | {2'b00, x_q[13:8]};
										job_d.bytes[1] = x_q[7:0];
										job_d.bytes[2] = y_q[15:8];
										job_d.bytes[3] = y_q[7:0];
										job_d.bytes[4] = {6'b0, btn_now_q};
										job_d.count    = PKT_LEN;
										btn_rep_d = btn_now_q;
										x_d = '0;
										y_d = '0;
										x_nz_d = 1'b0;
										y_nz_d = 1'b0;
									end
								end
								REG_1: begin
									job_d.bytes = ID_BYTES;
									job_d.count = ID_LEN;
								end
								REG_3: begin
									job_d.bytes[0] = {4'b0, addr_q};
									job_d.bytes[1] = handler_q;
									job_d.count    = REG3_LEN;
								end
								default: begin
								end
							endcase
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		job_d.has_data = (btn_now_d != btn_rep_d) || x_nz_d || y_nz_d;
	end

	assign job = job_d;

	// Commit state and configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			btn_now_q <= '0;
			btn_rep_q <= '0;
			x_q       <= '0;
			y_q       <= '0;
			addr_q    <= ADDR_DEFAULT;
			handler_q <= HANDLER_ID;
		end else begin
			if (cfg_write && cfg_index == CFG_WIDTH) width_q <= cfg_data;
			if (cfg_write && cfg_index == CFG_HEIGHT) height_q <= cfg_data;
			if (job_push) begin
				btn_now_q <= btn_now_d;
				btn_rep_q <= btn_rep_d;
				x_q       <= x_d;
				y_q       <= y_d;
				addr_q    <= addr_d;
				handler_q <= handler_d;
			end
		end
	end

	`ADBT_ASSERT(a_job_len, clk, arst_n, job_push |-> (job.count == '0 || job.count == REG3_LEN || job.count == PKT_LEN || job.count == ID_LEN), "job carries an impossible byte count")

endmodule

`default_nettype wire

[sv/adbt_back.sv]
// ----------------------------------------------------------------------------
// adbt_back
// Serializes queued jobs into one result per cycle through an output register, while the result sink is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "adb_tablet_device_core_macros.svh"

module adbt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  adbt_pkg::job_t job,
	input  logic           job_avail,
	output logic           job_pop,
	adbt_out_if.source     result
);
	import adbt_pkg::*;

	logic        cur_v_q;
	logic [63:0] cur_bytes_q;
	logic [3:0]  cur_rem_q;
	logic        cur_hd_q;

	logic        out_v_q;
	logic [7:0]  out_data_q;
	logic        out_bv_q;
	logic        out_last_q;
	logic        out_hd_q;

	logic load_out, emit, done, cur_free;

	assign load_out = !out_v_q || result.ready;
	assign emit     = cur_v_q && load_out;
	assign done     = emit && (cur_rem_q <= 4'd1);
	assign cur_free = !cur_v_q || done;
	assign job_pop  = cur_free && job_avail;

	// Track the active job and output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (job_pop) begin
				cur_v_q <= 1'b1;
			end else if (done) begin
				cur_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= cur_v_q;
			end
		end
	end

	// Shift out one byte per transfer; an empty job still yields one marker
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_bytes_q <= job.bytes;
			cur_rem_q   <= job.count;
			cur_hd_q    <= job.has_data;
		end else if (emit) begin
			cur_bytes_q <= {8'h00, cur_bytes_q[63:8]};
			cur_rem_q   <= cur_rem_q - 1'b1;
		end
		if (emit) begin
			out_data_q <= (cur_rem_q != '0) ? cur_bytes_q[7:0] : 8'h00;
			out_bv_q   <= (cur_rem_q != '0);
			out_last_q <= (cur_rem_q <= 4'd1);
			out_hd_q   <= cur_hd_q;
		end
	end

	assign result.valid      = out_v_q;
	assign result.data_byte  = out_data_q;
	assign result.byte_valid = out_bv_q;
	assign result.last       = out_last_q;
	assign result.has_data   = out_hd_q;

	`ADBT_ASSERT(a_empty_is_last, clk, arst_n, (out_v_q && !out_bv_q) |-> out_last_q, "byteless result not marked last")

endmodule

`default_nettype wire

[sv/adb_tablet_device_core.sv]
// ----------------------------------------------------------------------------
// adb_tablet_device_core
// ADB graphics tablet: host pointer events in, ADB response bytes out.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | content
//  item     | in  | valid/ready   | host move, button or ADB command
//  result   | out | valid/ready   | one response byte with flags
//  cfg      | in  | cfg_write     | display width (0) / height (1)
//
//  An item is taken every cycle while the job queue has room; state is applied
//  in front stage 3, and its job then passes through the queue and the serializer.
//  Results leave one per cycle from the serializer while the sink is ready, and
//  each item yields 1, 2, 5 or 8 results (8 for a talk to register 1).
//  Reset sets address 4, handler 0x3A, size 640x480 and clears all motion.
//  A stalled result sink fills the queue, then the front, then drops ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adb_tablet_device_core #(
	parameter int JOB_DEPTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [0:0]                      cfg_index,
	input  logic [adbt_pkg::CFG_DATA_W-1:0] cfg_data,
	adbt_in_if.sink                         item,
	adbt_out_if.source                      result
);
	import adbt_pkg::*;

	job_t front_job;
	job_t queue_job;
	logic job_push, job_full, job_pop, job_empty;

	adbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.job      (front_job),
		.job_push (job_push),
		.job_full (job_full)
	);

	adbt_fifo #(
		.DEPTH(JOB_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(front_job),
		.full     (job_full),
		.pop      (job_pop),
		.pop_data (queue_job),
		.empty    (job_empty)
	);

	adbt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (queue_job),
		.job_avail(!job_empty),
		.job_pop  (job_pop),
		.result   (result)
	);

endmodule

`default_nettype wire
